>>> hw/rtl/acre_pkg.sv
// Shared types and constants for the audio codec command ring engine.
`default_nettype none
package acre_pkg;

   localparam int PTR_W        = 8;
   localparam int SLOT_W       = 4;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_IDX_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int NUM_REGS     = 9;

   localparam logic [1:0] CMD_REG_WRITE = 2'd0;
   localparam logic [1:0] CMD_REG_READ  = 2'd1;
   localparam logic [1:0] CMD_TICK      = 2'd2;
   localparam logic [1:0] CMD_DMA_DATA  = 2'd3;

   localparam logic [1:0] KIND_NONE      = 2'd0;
   localparam logic [1:0] KIND_READ_DATA = 2'd1;
   localparam logic [1:0] KIND_DMA_READ  = 2'd2;
   localparam logic [1:0] KIND_DMA_WRITE = 2'd3;

   localparam logic [6:0] OFF_GCTL     = 7'h08;
   localparam logic [6:0] OFF_CORB_LO  = 7'h40;
   localparam logic [6:0] OFF_CORB_HI  = 7'h44;
   localparam logic [6:0] OFF_CORB_PTR = 7'h48;
   localparam logic [6:0] OFF_CORB_CTL = 7'h4c;
   localparam logic [6:0] OFF_RIRB_LO  = 7'h50;
   localparam logic [6:0] OFF_RIRB_HI  = 7'h54;
   localparam logic [6:0] OFF_RIRB_PTR = 7'h58;
   localparam logic [6:0] OFF_RIRB_CTL = 7'h5c;

   localparam logic [SLOT_W-1:0] SLOT_GCTL     = 4'd0;
   localparam logic [SLOT_W-1:0] SLOT_CORB_LO  = 4'd1;
   localparam logic [SLOT_W-1:0] SLOT_CORB_HI  = 4'd2;
   localparam logic [SLOT_W-1:0] SLOT_CORB_PTR = 4'd3;
   localparam logic [SLOT_W-1:0] SLOT_CORB_CTL = 4'd4;
   localparam logic [SLOT_W-1:0] SLOT_RIRB_LO  = 4'd5;
   localparam logic [SLOT_W-1:0] SLOT_RIRB_HI  = 4'd6;
   localparam logic [SLOT_W-1:0] SLOT_RIRB_PTR = 4'd7;
   localparam logic [SLOT_W-1:0] SLOT_RIRB_CTL = 4'd8;

   localparam int RUN_BIT        = 1;
   localparam int GCTL_RESET_BIT = 0;
   localparam int RIRB_RST_BIT   = 15;
   localparam int BASE_ALIGN_W   = 7;
   localparam int VERB_W         = 24;

   typedef struct packed {
      logic [1:0]        cmd;
      logic              slot_valid;
      logic [SLOT_W-1:0] slot;
      logic [31:0]       write_value;
      logic [31:0]       fetched_verb;
   } entry_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [31:0] read_value;
      logic [63:0] dma_address;
      logic [63:0] response_word;
      logic        raise_irq;
   } result_type;

endpackage
`default_nettype wire

>>> hw/rtl/acre_front.sv
// Request intake: decodes command and register offset into a queue entry.
`default_nettype none
module acre_front (
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_command,
   input  wire logic [6:0]         req_reg_offset,
   input  wire logic [31:0]        req_write_value,
   input  wire logic [31:0]        req_fetched_verb,
   input  wire logic               q_full,
   output logic                    q_push,
   output acre_pkg::entry_type     q_entry
);
   import acre_pkg::*;

   logic              slot_valid;
   logic [SLOT_W-1:0] slot;

   always_comb begin
      slot_valid = 1'b1;
      slot       = SLOT_GCTL;
      case (req_reg_offset)
         OFF_GCTL:     slot = SLOT_GCTL;
         OFF_CORB_LO:  slot = SLOT_CORB_LO;
         OFF_CORB_HI:  slot = SLOT_CORB_HI;
         OFF_CORB_PTR: slot = SLOT_CORB_PTR;
         OFF_CORB_CTL: slot = SLOT_CORB_CTL;
         OFF_RIRB_LO:  slot = SLOT_RIRB_LO;
         OFF_RIRB_HI:  slot = SLOT_RIRB_HI;
         OFF_RIRB_PTR: slot = SLOT_RIRB_PTR;
         OFF_RIRB_CTL: slot = SLOT_RIRB_CTL;
         default:      slot_valid = 1'b0;
      endcase
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_entry.cmd          = req_command;
      q_entry.slot_valid   = slot_valid;
      q_entry.slot         = slot;
      q_entry.write_value  = req_write_value;
      q_entry.fetched_verb = req_fetched_verb;
   end

endmodule
`default_nettype wire

>>> hw/rtl/acre_queue.sv
// Short request queue between intake and execution.
`default_nettype none
module acre_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire acre_pkg::entry_type push_entry,
   output logic                     full,
   input  wire logic                pop,
   output logic                     not_empty,
   output acre_pkg::entry_type      head
);
   import acre_pkg::*;

   entry_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? QUEUE_IDX_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? QUEUE_IDX_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = QUEUE_CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = QUEUE_CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/acre_back.sv
// Execution: register bank, ring pointers, DMA sequencing and response register.
`default_nettype none
module acre_back #(
   parameter int RING_ENTRIES = 256
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   input  wire acre_pkg::entry_type q_entry,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output acre_pkg::result_type     rsp_result
);
   import acre_pkg::*;

   localparam int TBL_SIZE = 2 ** PTR_W;

   typedef logic [PTR_W-1:0] next_tbl_type [TBL_SIZE];

   function automatic next_tbl_type build_next_tbl();
      next_tbl_type t;
      for (int i = 0; i < TBL_SIZE; i++) begin
         t[i] = PTR_W'((i + 1) % RING_ENTRIES);
      end
      return t;
   endfunction

   localparam next_tbl_type NEXT_TBL = build_next_tbl();

   logic [31:0]      bank_ff [NUM_REGS];
   logic [31:0]      bank_in [NUM_REGS];
   logic [PTR_W-1:0] crp_ff, crp_in;
   logic [PTR_W-1:0] rwp_ff, rwp_in;
   logic             await_ff, await_in;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_ff, rsp_in;

   logic             take;
   logic             ring_rst;
   logic [PTR_W-1:0] crp_next, rwp_next, wp;
   logic [63:0]      cmd_ring_base, resp_ring_base;

   assign take      = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign q_pop     = take;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_result = rsp_ff;

   assign crp_next  = NEXT_TBL[crp_ff];
   assign rwp_next  = NEXT_TBL[rwp_ff];
   assign wp        = bank_ff[SLOT_CORB_PTR][PTR_W-1:0];
   assign cmd_ring_base  = {bank_ff[SLOT_CORB_HI],
                            bank_ff[SLOT_CORB_LO][31:BASE_ALIGN_W], BASE_ALIGN_W'(0)};
   assign resp_ring_base = {bank_ff[SLOT_RIRB_HI],
                            bank_ff[SLOT_RIRB_LO][31:BASE_ALIGN_W], BASE_ALIGN_W'(0)};

   always_comb begin
      bank_in      = bank_ff;
      crp_in       = crp_ff;
      rwp_in       = rwp_ff;
      await_in     = await_ff;
      ring_rst     = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (take) begin
         rsp_valid_in          = 1'b1;
         rsp_in.result_kind    = KIND_NONE;
         rsp_in.read_value     = '0;
         rsp_in.dma_address    = '0;
         rsp_in.response_word  = '0;
         rsp_in.raise_irq      = 1'b0;
         case (q_entry.cmd)
            CMD_REG_WRITE: begin
               if (q_entry.slot_valid) begin
                  bank_in[q_entry.slot] = q_entry.write_value;
                  case (q_entry.slot)
                     SLOT_GCTL:     ring_rst = !q_entry.write_value[GCTL_RESET_BIT];
                     SLOT_CORB_PTR: crp_in = q_entry.write_value[16 +: PTR_W];
                     SLOT_RIRB_PTR: ring_rst = q_entry.write_value[RIRB_RST_BIT];
                     default: ;
                  endcase
               end
            end
            CMD_REG_READ: begin
               rsp_in.result_kind = KIND_READ_DATA;
               if (q_entry.slot_valid) begin
                  rsp_in.read_value = bank_ff[q_entry.slot];
               end
            end
            CMD_TICK: begin
               if (!await_ff && bank_ff[SLOT_CORB_CTL][RUN_BIT]
                   && bank_ff[SLOT_RIRB_CTL][RUN_BIT] && wp != crp_ff) begin
                  rsp_in.result_kind = KIND_DMA_READ;
                  rsp_in.dma_address = cmd_ring_base + {54'd0, crp_next, 2'b00};
                  await_in           = 1'b1;
               end
            end
            CMD_DMA_DATA: begin
               if (await_ff) begin
                  await_in  = 1'b0;
                  crp_in    = crp_next;
                  rwp_in    = rwp_next;
                  rsp_in.result_kind   = KIND_DMA_WRITE;
                  rsp_in.response_word = {8'd0, q_entry.fetched_verb[VERB_W-1:0], 32'd0};
                  rsp_in.dma_address   = resp_ring_base + {53'd0, rwp_next, 3'b000};
                  rsp_in.raise_irq     = 1'b1;
                  bank_in[SLOT_CORB_PTR] = {8'd0, crp_next, 8'd0, wp};
                  bank_in[SLOT_RIRB_PTR] = {24'd0, rwp_next};
               end
            end
            default: ;
         endcase
         if (ring_rst) begin
            crp_in   = '0;
            rwp_in   = '0;
            await_in = 1'b0;
            bank_in[SLOT_CORB_PTR] = '0;
            bank_in[SLOT_RIRB_PTR] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            bank_ff[i] <= '0;
         end
         crp_ff       <= '0;
         rwp_ff       <= '0;
         await_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bank_ff      <= bank_in;
         crp_ff       <= crp_in;
         rwp_ff       <= rwp_in;
         await_ff     <= await_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule
`default_nettype wire

>>> hw/rtl/audio_codec_command_ring_engine.sv
// Top level of the audio codec command ring engine.
// Every request (register write, register read, service tick, DMA data return) yields
// exactly one response, in order. A request is taken every cycle while the two-entry
// queue has room; the execution stage retires one request per cycle into the response
// register whenever that register is empty or being drained, so sustained rate is one
// request per cycle, via the queue and the response register. Unlisted offsets read
// zero and ignore writes; pointers wrap modulo RING_ENTRIES.
`default_nettype none
module audio_codec_command_ring_engine #(
   parameter int RING_ENTRIES = 256
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [1:0]   req_command,
   input  wire logic [6:0]   req_reg_offset,
   input  wire logic [31:0]  req_write_value,
   input  wire logic [31:0]  req_fetched_verb,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [1:0]        rsp_result_kind,
   output logic [31:0]       rsp_read_value,
   output logic [63:0]       rsp_dma_address,
   output logic [63:0]       rsp_response_word,
   output logic              rsp_raise_irq
);
   import acre_pkg::*;

   entry_type  push_entry, head;
   logic       q_full, q_push, q_pop, q_not_empty;
   result_type result;

   acre_front u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_reg_offset   (req_reg_offset),
      .req_write_value  (req_write_value),
      .req_fetched_verb (req_fetched_verb),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (push_entry)
   );

   acre_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head       (head)
   );

   acre_back #(
      .RING_ENTRIES (RING_ENTRIES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_not_empty),
      .q_entry    (head),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (result)
   );

   assign rsp_result_kind   = result.result_kind;
   assign rsp_read_value    = result.read_value;
   assign rsp_dma_address   = result.dma_address;
   assign rsp_response_word = result.response_word;
   assign rsp_raise_irq     = result.raise_irq;

endmodule
`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for the audio codec command ring engine.
module tb_top;
   import acre_pkg::*;

   localparam int ITEMS        = 1550;
   localparam int LIMIT        = 400000;
   localparam int DRAIN_CYCLES = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = CMD_REG_READ;
   logic [6:0]  req_reg_offset = '0;
   logic [31:0] req_write_value = '0;
   logic [31:0] req_fetched_verb = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [31:0] rsp_read_value;
   logic [63:0] rsp_dma_address;
   logic [63:0] rsp_response_word;
   logic        rsp_raise_irq;

   logic [6:0] reg_offsets [9] = '{OFF_GCTL, OFF_CORB_LO, OFF_CORB_HI, OFF_CORB_PTR,
                                   OFF_CORB_CTL, OFF_RIRB_LO, OFF_RIRB_HI, OFF_RIRB_PTR,
                                   OFF_RIRB_CTL};
   logic [6:0] base_offsets [4] = '{OFF_CORB_LO, OFF_CORB_HI, OFF_RIRB_LO, OFF_RIRB_HI};

   int cycles = 0;
   int sent = 0;
   int useful = 0;
   bit tx_burst = 1'b0;
   bit rx_burst = 1'b0;

   class cmd_ring_tracker;
      localparam int RING = 256;

      logic [31:0] bank [NUM_REGS];
      logic [7:0]  cmd_rp;
      logic [7:0]  resp_wp;
      bit          fetch_pending;
      result_type  awaited_rsp [$];
      int          errors;
      int          checked;
      int          fetches;
      int          rsp_writes;
      int          ring_resets;

      function new();
         foreach (bank[k]) bank[k] = '0;
         cmd_rp = '0;
         resp_wp = '0;
         fetch_pending = 1'b0;
         errors = 0;
         checked = 0;
         fetches = 0;
         rsp_writes = 0;
         ring_resets = 0;
      endfunction

      function int bank_index(logic [6:0] off);
         case (off)
            OFF_GCTL:     return SLOT_GCTL;
            OFF_CORB_LO:  return SLOT_CORB_LO;
            OFF_CORB_HI:  return SLOT_CORB_HI;
            OFF_CORB_PTR: return SLOT_CORB_PTR;
            OFF_CORB_CTL: return SLOT_CORB_CTL;
            OFF_RIRB_LO:  return SLOT_RIRB_LO;
            OFF_RIRB_HI:  return SLOT_RIRB_HI;
            OFF_RIRB_PTR: return SLOT_RIRB_PTR;
            OFF_RIRB_CTL: return SLOT_RIRB_CTL;
            default:      return -1;
         endcase
      endfunction

      function logic [7:0] next_ptr(logic [7:0] p);
         return 8'((int'(p) + 1) % RING);
      endfunction

      function logic [63:0] ring_base(int lo, int hi);
         return {bank[hi], bank[lo] & ~32'h7f};
      endfunction

      function void clear_rings();
         cmd_rp = '0;
         resp_wp = '0;
         fetch_pending = 1'b0;
         bank[SLOT_CORB_PTR] = '0;
         bank[SLOT_RIRB_PTR] = '0;
         ring_resets++;
      endfunction

      // returns 1 when the request had a visible effect
      function bit note_request(logic [1:0] cmd, logic [6:0] off, logic [31:0] wval,
                                logic [31:0] verb);
         result_type r;
         int         idx;
         logic [7:0] wp;
         bit         effect;
         r = '0;
         effect = 1'b0;
         idx = bank_index(off);
         wp = bank[SLOT_CORB_PTR][7:0];
         case (cmd)
            CMD_REG_WRITE: begin
               if (idx >= 0) begin
                  effect = 1'b1;
                  bank[idx] = wval;
                  if (off == OFF_GCTL && !wval[GCTL_RESET_BIT]) clear_rings();
                  else if (off == OFF_CORB_PTR) cmd_rp = wval[23:16];
                  else if (off == OFF_RIRB_PTR && wval[RIRB_RST_BIT]) clear_rings();
               end
            end
            CMD_REG_READ: begin
               effect = 1'b1;
               r.result_kind = KIND_READ_DATA;
               if (idx >= 0) r.read_value = bank[idx];
            end
            CMD_TICK: begin
               if (!fetch_pending && bank[SLOT_CORB_CTL][RUN_BIT] &&
                   bank[SLOT_RIRB_CTL][RUN_BIT] && wp != cmd_rp) begin
                  effect = 1'b1;
                  r.result_kind = KIND_DMA_READ;
                  r.dma_address = ring_base(SLOT_CORB_LO, SLOT_CORB_HI) +
                                  64'(next_ptr(cmd_rp)) * 4;
                  fetch_pending = 1'b1;
                  fetches++;
               end
            end
            CMD_DMA_DATA: begin
               if (fetch_pending) begin
                  effect = 1'b1;
                  fetch_pending = 1'b0;
                  cmd_rp = next_ptr(cmd_rp);
                  resp_wp = next_ptr(resp_wp);
                  r.result_kind = KIND_DMA_WRITE;
                  r.response_word = {8'h00, verb[VERB_W-1:0], 32'h0};
                  r.dma_address = ring_base(SLOT_RIRB_LO, SLOT_RIRB_HI) + 64'(resp_wp) * 8;
                  r.raise_irq = 1'b1;
                  bank[SLOT_CORB_PTR] = {8'h00, cmd_rp, 8'h00, wp};
                  bank[SLOT_RIRB_PTR] = {24'h0, resp_wp};
                  rsp_writes++;
               end
            end
            default: ;
         endcase
         awaited_rsp.push_back(r);
         return effect;
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         $display("MISMATCH %s: got %h expected %h", what, got, want);
         errors++;
      endtask

      task check_result(result_type got);
         result_type want;
         if (awaited_rsp.size() == 0) begin
            report("unexpected response, kind", 64'(got.result_kind), 64'(0));
            return;
         end
         want = awaited_rsp.pop_front();
         checked++;
         if (got.result_kind !== want.result_kind)
            report("result_kind", 64'(got.result_kind), 64'(want.result_kind));
         if (got.read_value !== want.read_value)
            report("read_value", 64'(got.read_value), 64'(want.read_value));
         if (got.dma_address !== want.dma_address)
            report("dma_address", got.dma_address, want.dma_address);
         if (got.response_word !== want.response_word)
            report("response_word", got.response_word, want.response_word);
         if (got.raise_irq !== want.raise_irq)
            report("raise_irq", 64'(got.raise_irq), 64'(want.raise_irq));
      endtask
   endclass

   cmd_ring_tracker tracker;

   audio_codec_command_ring_engine i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_reg_offset    (req_reg_offset),
      .req_write_value   (req_write_value),
      .req_fetched_verb  (req_fetched_verb),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_read_value    (rsp_read_value),
      .rsp_dma_address   (rsp_dma_address),
      .rsp_response_word (rsp_response_word),
      .rsp_raise_irq     (rsp_raise_irq)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("TIMEOUT after %0d cycles", cycles);
         $display("tb_top failed");
         $finish;
      end
   end

   task automatic send(logic [1:0] cmd, logic [6:0] off, logic [31:0] wval,
                       logic [31:0] verb);
      int gap;
      if ($urandom_range(0, 59) == 0) tx_burst = !tx_burst;
      gap = tx_burst ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_reg_offset <= off;
      req_write_value <= wval;
      req_fetched_verb <= verb;
      do @(posedge clock); while (req_stall);
      sent++;
      if (tracker.note_request(cmd, off, wval, verb)) useful++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tracker.awaited_rsp.size() != 0) @(posedge clock);
   endtask

   // response side
   initial begin
      int         n;
      result_type got;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 59) == 0) rx_burst = !rx_burst;
         n = rx_burst ? 0 : $urandom_range(0, 10);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got.result_kind = rsp_result_kind;
         got.read_value = rsp_read_value;
         got.dma_address = rsp_dma_address;
         got.response_word = rsp_response_word;
         got.raise_irq = rsp_raise_irq;
         tracker.check_result(got);
      end
   end

   initial begin
      int          n;
      int          pick;
      logic [31:0] val;
      logic [6:0]  off;
      tracker = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: reset values, unlisted offsets, idle ticks, ring setup and wrap
      send(CMD_REG_READ, OFF_GCTL, '0, '0);
      send(CMD_REG_READ, 7'h7f, '0, '0);
      send(CMD_REG_WRITE, 7'h42, 32'hffffffff, '0);
      send(CMD_REG_READ, OFF_CORB_LO, '0, '0);
      send(CMD_TICK, '0, '0, '0);
      send(CMD_DMA_DATA, '0, '0, 32'hffffffff);
      send(CMD_REG_WRITE, OFF_CORB_LO, 32'hffffffff, '0);
      send(CMD_REG_WRITE, OFF_CORB_HI, 32'hffffffff, '0);
      send(CMD_REG_WRITE, OFF_RIRB_LO, 32'hffffff80, '0);
      send(CMD_REG_WRITE, OFF_RIRB_HI, 32'h00000000, '0);
      send(CMD_REG_WRITE, OFF_GCTL, 32'h00000001, '0);
      send(CMD_REG_WRITE, OFF_CORB_CTL, 32'h00000002, '0);
      send(CMD_REG_WRITE, OFF_RIRB_CTL, 32'hffffffff, '0);
      send(CMD_TICK, '0, '0, '0);
      send(CMD_REG_WRITE, OFF_CORB_PTR, 32'hffff0005, '0);
      send(CMD_TICK, '0, '0, '0);
      send(CMD_TICK, '0, '0, '0);
      send(CMD_DMA_DATA, '0, '0, 32'hffffffff);
      send(CMD_TICK, '0, '0, '0);
      send(CMD_REG_WRITE, OFF_CORB_CTL, 32'h00000000, '0);
      send(CMD_DMA_DATA, '0, '0, 32'h00000000);
      send(CMD_REG_READ, OFF_CORB_PTR, '0, '0);
      send(CMD_REG_WRITE, OFF_RIRB_PTR, 32'h00008000, '0);
      send(CMD_REG_READ, OFF_RIRB_PTR, '0, '0);
      send(CMD_REG_WRITE, OFF_CORB_CTL, 32'h00000002, '0);
      send(CMD_TICK, '0, '0, '0);
      send(CMD_REG_WRITE, OFF_GCTL, 32'hfffffffe, '0);
      send(CMD_DMA_DATA, '0, '0, 32'h12345678);
      wait_drained();

      n = 0;
      while (sent < ITEMS) begin
         n++;
         if (n % 400 == 0) wait_drained();
         pick = $urandom_range(0, 99);
         val = $urandom;
         off = 7'($urandom);
         if (pick < 30) begin
            send(CMD_TICK, off, val, $urandom);
         end else if (pick < 55) begin
            send(CMD_DMA_DATA, off, $urandom, val);
         end else if (pick < 67) begin
            send(CMD_REG_WRITE, OFF_CORB_PTR, val, $urandom);
         end else if (pick < 75) begin
            if ($urandom_range(0, 4) != 0) off = reg_offsets[$urandom_range(0, 8)];
            send(CMD_REG_READ, off, val, $urandom);
         end else if (pick < 81) begin
            val[RUN_BIT] = ($urandom_range(0, 6) != 0);
            send(CMD_REG_WRITE, $urandom_range(0, 1) ? OFF_CORB_CTL : OFF_RIRB_CTL, val,
                 $urandom);
         end else if (pick < 86) begin
            send(CMD_REG_WRITE, base_offsets[$urandom_range(0, 3)], val, $urandom);
         end else if (pick < 89) begin
            val[GCTL_RESET_BIT] = ($urandom_range(0, 4) != 0);
            send(CMD_REG_WRITE, OFF_GCTL, val, $urandom);
         end else if (pick < 92) begin
            send(CMD_REG_WRITE, OFF_RIRB_PTR, val, $urandom);
         end else begin
            send(2'($urandom), off, val, $urandom);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Summary: %0d requests sent (%0d with effect), %0d responses checked",
               sent, useful, tracker.checked);
      $display("Summary: %0d CORB fetches, %0d RIRB writes, %0d ring resets, %0d mismatches",
               tracker.fetches, tracker.rsp_writes, tracker.ring_resets, tracker.errors);
      if (tracker.errors == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
